@@ hdl/crcab_pkg.sv @@
// Shared types, constants and the CRC table function for the CRC-32 byte stream block.
`timescale 1ns / 1ps
`default_nettype none

package crcab_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned LaneCnt = CrcW / ByteW;
  localparam int unsigned CntW    = $clog2(LaneCnt + 1);

  localparam logic [CrcW-1:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;

  // One byte handed from the input stage to the accumulator.
  typedef struct packed {
    logic             en;
    logic             last;
    logic [ByteW-1:0] data;
  } step_t;

  // Table entry: the index in the top byte, reduced over eight MSB-first shifts.
  function automatic logic [CrcW-1:0] crc_table(input logic [ByteW-1:0] idx);
    logic [CrcW-1:0] w;
    w = {idx, {(CrcW - ByteW){1'b0}}};
    for (int k = 0; k < ByteW; k++) begin
      if (w[CrcW-1]) begin
        w = (w << 1) ^ CrcPoly;
      end else begin
        w = w << 1;
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/crcab_if.sv @@
// Stream interfaces for the byte input and the CRC result channels.
`timescale 1ns / 1ps
`default_nettype none

interface crcab_in_if;
  logic                       valid;
  logic                       ready;
  logic [crcab_pkg::ByteW-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcab_out_if;
  logic                       valid;
  logic                       ready;
  logic [crcab_pkg::CrcW-1:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

@@ hdl/crcab_acc.sv @@
// CRC accumulator: lane packing for the first four bytes, table update after that.
`timescale 1ns / 1ps
`default_nettype none

module crcab_acc (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire crcab_pkg::step_t            step_i,
  output logic [crcab_pkg::CrcW-1:0]       crc_o
);

  logic [crcab_pkg::CrcW-1:0] acc_q, acc_d, acc_upd;
  logic [crcab_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [crcab_pkg::CrcW-1:0] lane_word;

  // Place the byte into the lane picked by the byte count, top lane first.
  always_comb begin
    lane_word = '0;
    for (int l = 0; l < crcab_pkg::LaneCnt; l++) begin
      if (cnt_q == crcab_pkg::CntW'(l)) begin
        lane_word[crcab_pkg::CrcW-1-l*crcab_pkg::ByteW -: crcab_pkg::ByteW] = step_i.data;
      end
    end
  end

  // Next accumulator value for this byte.
  always_comb begin
    if (cnt_q < crcab_pkg::CntW'(crcab_pkg::LaneCnt)) begin
      acc_upd = acc_q ^ lane_word;
    end else begin
      acc_upd = {acc_q[crcab_pkg::CrcW-crcab_pkg::ByteW-1:0], step_i.data}
              ^ crcab_pkg::crc_table(acc_q[crcab_pkg::CrcW-1 -: crcab_pkg::ByteW]);
    end
  end

  assign crc_o = ~acc_upd;

  // State update; the last byte of a message returns to the initial state.
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (step_i.en) begin
      if (step_i.last) begin
        acc_d = crcab_pkg::CrcInit;
        cnt_d = '0;
      end else begin
        acc_d = acc_upd;
        if (cnt_q < crcab_pkg::CntW'(crcab_pkg::LaneCnt)) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= crcab_pkg::CrcInit;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/crc32_augmented_byte_stream.sv @@
// Top level of the CRC-32 byte stream block: input register, accumulator, result register.
//
//   Channel   Dir  Word contents
//   in_i      in   data_byte[7:0], last_byte
//   out_o     out  crc_value[31:0], one word per message
//
// One byte is taken per cycle while in_i.ready is high. A byte goes into an input
// register and is folded into the accumulator as it moves on, the same edge that loads
// the CRC of a message into the result register when it is the message's last byte.
// Reset returns the accumulator to all ones and empties both registers.
// in_i.ready drops only while a finished CRC waits in the result register, a last
// byte sits in the input register and out_o.ready is low.
`timescale 1ns / 1ps
`default_nettype none

module crc32_augmented_byte_stream (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  crcab_in_if.sink   in_i,
  crcab_out_if.source out_o
);

  logic                        s1_valid_q, s1_valid_d;
  logic [crcab_pkg::ByteW-1:0] s1_data_q;
  logic                        s1_last_q;
  logic                        s1_go;
  logic                        in_take;

  logic                        out_valid_q, out_valid_d;
  logic [crcab_pkg::CrcW-1:0]  out_crc_q;
  logic [crcab_pkg::CrcW-1:0]  crc_w;
  crcab_pkg::step_t            step;

  // The held byte moves on unless it finishes a message and the result is still held.
  assign s1_go   = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_take = in_i.valid && in_i.ready;

  assign step.en   = s1_go;
  assign step.last = s1_last_q;
  assign step.data = s1_data_q;

  crcab_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .crc_o  (crc_w)
  );

  // Input register.
  assign s1_valid_d = in_take || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // Result register.
  assign out_valid_d = (s1_go && s1_last_q) || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_crc_q <= crc_w;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = out_crc_q;

endmodule

`default_nettype wire

@@ hdl/crcab_checker.sv @@
// Port-level checks for the CRC-32 byte stream block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module crcab_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       in_last_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [crcab_pkg::CrcW-1:0] out_crc_i
);

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_crc_i))
    else $error("result word changed while stalled");

  // The input side stalls only behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  // A new result follows an accepted last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("result without a matching last byte");

endmodule

bind crc32_augmented_byte_stream crcab_checker u_crcab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_crc_i   (out_o.crc_value)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the CRC-32 augmented byte stream block.
`timescale 1ns / 1ps

module testbench;
  localparam int unsigned ByteW = crcab_pkg::ByteW;
  localparam int unsigned CrcW  = crcab_pkg::CrcW;

  // One input word as queued for the driver, with the idle cycles to insert before it.
  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
    int unsigned      gap;
  } byte_word_t;

  localparam int unsigned LaneTotal = CrcW / ByteW;
  localparam logic [CrcW-1:0] GenPoly = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] AccSeed = 32'hFFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  crcab_in_if  byte_if ();
  crcab_out_if crc_if ();

  crc32_augmented_byte_stream dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (crc_if)
  );

  byte_word_t      pending_bytes_q[$];
  logic [CrcW-1:0] crc_expect_q[$];
  logic [CrcW-1:0] crc_rom[256];
  logic [CrcW-1:0] model_acc;
  int unsigned     model_lanes;
  int unsigned     error_count;
  int unsigned     sink_hold;

  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // Remainder of an index byte placed at the top of the word, reduced bit by bit.
  function automatic logic [CrcW-1:0] reduce_top_byte(input int unsigned idx);
    logic [CrcW-1:0] rem;
    logic            msb;
    rem = CrcW'(idx) << (CrcW - ByteW);
    repeat (ByteW) begin
      msb = rem[CrcW-1];
      rem = {rem[CrcW-2:0], 1'b0};
      if (msb) begin
        rem = rem ^ GenPoly;
      end
    end
    return rem;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Fold one accepted word into the model; a last word yields the expected CRC.
  task automatic fold_byte(input logic [ByteW-1:0] data, input logic last);
    logic [ByteW-1:0] top;
    if (model_lanes < LaneTotal) begin
      model_acc   = model_acc ^ (CrcW'(data) << (CrcW - ByteW * (model_lanes + 1)));
      model_lanes = model_lanes + 1;
    end else begin
      top       = model_acc[CrcW-1 -: ByteW];
      model_acc = {model_acc[CrcW-ByteW-1:0], data} ^ crc_rom[top];
    end
    if (last) begin
      crc_expect_q.push_back(~model_acc);
      model_acc   = AccSeed;
      model_lanes = 0;
    end
  endtask

  task automatic queue_message(input logic [ByteW-1:0] bytes[$], input bit calm);
    byte_word_t w;
    foreach (bytes[i]) begin
      w.data = bytes[i];
      w.last = (i == bytes.size() - 1);
      w.gap  = calm ? 0 : pick_gap();
      pending_bytes_q.push_back(w);
    end
  endtask

  // Driver: presents the next queued word once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid     <= 1'b0;
      byte_if.data_byte <= '0;
      byte_if.last_byte <= 1'b0;
    end else if (!byte_if.valid || byte_if.ready) begin
      if (pending_bytes_q.size() == 0) begin
        byte_if.valid <= 1'b0;
      end else if (pending_bytes_q[0].gap > 0) begin
        pending_bytes_q[0].gap = pending_bytes_q[0].gap - 1;
        byte_if.valid <= 1'b0;
      end else begin
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= pending_bytes_q[0].data;
        byte_if.last_byte <= pending_bytes_q[0].last;
        void'(pending_bytes_q.pop_front());
      end
    end
  end

  // Result sink: ready toggles in random stretches, some long and stall free.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_if.ready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
    end else if ($urandom_range(0, 3) != 0) begin
      crc_if.ready <= 1'b1;
      sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
    end else begin
      crc_if.ready <= 1'b0;
      sink_hold = pick_gap();
    end
  end

  // Monitor: predicts on accepted input words and checks accepted results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (crc_if.valid && crc_if.ready) begin
        if (crc_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected CRC word %08h", crc_if.crc_value));
        end else begin
          if (crc_if.crc_value !== crc_expect_q[0]) begin
            report_mismatch($sformatf("crc_value %08h, expected %08h",
                                      crc_if.crc_value, crc_expect_q[0]));
          end
          void'(crc_expect_q.pop_front());
        end
      end
      if (byte_if.valid && byte_if.ready) begin
        fold_byte(byte_if.data_byte, byte_if.last_byte);
      end
    end
  end

  initial begin
    logic [ByteW-1:0] msg[$];
    int unsigned      len;
    int unsigned      sent;
    int unsigned      r;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    crc_if.ready      = 1'b0;
    error_count = 0;
    model_acc   = AccSeed;
    model_lanes = 0;
    for (int i = 0; i < 256; i++) begin
      crc_rom[i] = reduce_top_byte(i);
    end

    // Directed: single bytes at the extremes, short messages, exactly four lanes, longer.
    msg = '{8'h00};                      queue_message(msg, 1'b1);
    msg = '{8'hFF};                      queue_message(msg, 1'b0);
    msg = '{8'h80};                      queue_message(msg, 1'b1);
    msg = '{8'h01};                      queue_message(msg, 1'b0);
    msg = '{8'hFF, 8'h00};               queue_message(msg, 1'b1);
    msg = '{8'h12, 8'h34, 8'h56};        queue_message(msg, 1'b0);
    msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF}; queue_message(msg, 1'b1);
    msg = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35}; queue_message(msg, 1'b0);
    msg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; queue_message(msg, 1'b1);

    // Random messages, mostly short, some spanning many shift steps.
    sent = 0;
    while (sent < 750) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        len = $urandom_range(1, 4);
      end else if (r < 85) begin
        len = $urandom_range(5, 12);
      end else begin
        len = $urandom_range(13, 40);
      end
      msg.delete();
      repeat (len) begin
        r = $urandom_range(0, 9);
        msg.push_back(r == 0 ? 8'h00 : (r == 1 ? 8'hFF : ByteW'($urandom_range(0, 255))));
      end
      queue_message(msg, $urandom_range(0, 4) == 0);
      sent += len;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all words taken, all results in, then a wait for stray output.
    do @(posedge clk_i); while (pending_bytes_q.size() != 0 || byte_if.valid);
    do @(posedge clk_i); while (crc_expect_q.size() != 0);
    repeat (10) @(posedge clk_i);
    if (crc_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d CRC words never arrived", crc_expect_q.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
